@@ sv/sit_pkg.sv @@
// Package for the segment intersection test.
// Holds the pipeline depth, the cross product sign type and the straddle
// decision. It depends on nothing.
`timescale 1ns / 1ps

package sit_pkg;

	localparam int unsigned PIPE_DEPTH = 3;

	typedef struct packed {
		logic neg;
		logic pos;
	} sign_t;

	function automatic logic product_nonneg(sign_t u, sign_t v);
		return !((u.pos && v.neg) || (u.neg && v.pos));
	endfunction

endpackage

@@ sv/sit_in_if.sv @@
// Input channel of the segment intersection test: valid, ready and the
// four endpoints of two segments. It depends on nothing.
`timescale 1ns / 1ps

interface sit_in_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_start_x;
	logic signed [COORD_WIDTH-1:0] a_start_y;
	logic signed [COORD_WIDTH-1:0] a_end_x;
	logic signed [COORD_WIDTH-1:0] a_end_y;
	logic signed [COORD_WIDTH-1:0] b_start_x;
	logic signed [COORD_WIDTH-1:0] b_start_y;
	logic signed [COORD_WIDTH-1:0] b_end_x;
	logic signed [COORD_WIDTH-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);

	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		input  b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

@@ sv/sit_out_if.sv @@
// Output channel of the segment intersection test: valid, ready and the
// one-bit result. It depends on nothing.
`timescale 1ns / 1ps

interface sit_out_if;
	logic valid;
	logic ready;
	logic intersects;

	modport source (
		output valid, intersects,
		input  ready
	);

	modport sink (
		input  valid, intersects,
		output ready
	);
endinterface

@@ sv/segment_intersection_test.sv @@
// Segment intersection test: decides whether two segments touch or cross.
// Uses sit_pkg and the channel interfaces sit_in_if and sit_out_if.
//
// A transaction on seg_in carries two segments, each as a start and an end
// point in signed two's complement coordinates of COORD_WIDTH bits. For each
// one, exactly one transaction leaves on seg_out carrying intersects, in the
// order of arrival.
// The work runs in three register stages: endpoint differences and the
// bounding box test, the eight cross product multiplications, then the
// cross product subtractions with the sign tests. The third stage is the
// output register, which shows the result. One pair is taken in every cycle
// unless the receiver stalls with the pipeline full; the multiplier stage sets
// the clock period.
// Each stage moves on when it is empty or the stage after it moves, so a
// stalled receiver holds its result while the empty stages in front of it
// still fill; seg_in.ready drops only when all three stages are occupied.
// Nothing is lost or repeated across a stall.
// Reset clears every valid bit; the block takes a transaction in the first
// cycle after reset.
`timescale 1ns / 1ps

module segment_intersection_test
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sit_in_if.sink    seg_in,
	sit_out_if.source seg_out
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;

	logic signed [DW-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
	logic signed [DW-1:0] amin_x, amax_x, bmin_x, bmax_x;
	logic signed [DW-1:0] amin_y, amax_y, bmin_y, bmax_y;
	logic                 ovl;

	logic                 v_s1, v_s2, v_s3;
	logic                 rdy1, rdy2, rdy3;

	logic signed [DW-1:0] d1x_s1, d1y_s1, qdx_s1, qdy_s1, d2x_s1, d2y_s1;
	logic signed [DW-1:0] e1x_s1, e1y_s1, pdx_s1, pdy_s1, e2x_s1, e2y_s1;
	logic                 ovl_s1;

	logic signed [PW-1:0] m1a_s2, m1b_s2, m2a_s2, m2b_s2;
	logic signed [PW-1:0] m3a_s2, m3b_s2, m4a_s2, m4b_s2;
	logic                 ovl_s2;

	logic signed [CW-1:0] c1, c2, c3, c4;
	sign_t                s1g, s2g, s3g, s4g;
	logic                 hit;
	logic                 intersects_s3;

	assign p1x = DW'(seg_in.a_start_x);
	assign p1y = DW'(seg_in.a_start_y);
	assign p2x = DW'(seg_in.a_end_x);
	assign p2y = DW'(seg_in.a_end_y);
	assign q1x = DW'(seg_in.b_start_x);
	assign q1y = DW'(seg_in.b_start_y);
	assign q2x = DW'(seg_in.b_end_x);
	assign q2y = DW'(seg_in.b_end_y);

	assign amin_x = (p1x < p2x) ? p1x : p2x;
	assign amax_x = (p1x < p2x) ? p2x : p1x;
	assign bmin_x = (q1x < q2x) ? q1x : q2x;
	assign bmax_x = (q1x < q2x) ? q2x : q1x;
	assign amin_y = (p1y < p2y) ? p1y : p2y;
	assign amax_y = (p1y < p2y) ? p2y : p1y;
	assign bmin_y = (q1y < q2y) ? q1y : q2y;
	assign bmax_y = (q1y < q2y) ? q2y : q1y;

	assign ovl = (amin_x <= bmax_x) && (bmin_x <= amax_x) &&
	             (amin_y <= bmax_y) && (bmin_y <= amax_y);

	assign rdy3 = !v_s3 || seg_out.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign seg_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= seg_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && seg_in.valid) begin
			d1x_s1 <= p1x - q1x;
			d1y_s1 <= p1y - q1y;
			qdx_s1 <= q2x - q1x;
			qdy_s1 <= q2y - q1y;
			d2x_s1 <= p2x - q1x;
			d2y_s1 <= p2y - q1y;
			e1x_s1 <= q1x - p1x;
			e1y_s1 <= q1y - p1y;
			pdx_s1 <= p2x - p1x;
			pdy_s1 <= p2y - p1y;
			e2x_s1 <= q2x - p1x;
			e2y_s1 <= q2y - p1y;
			ovl_s1 <= ovl;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			m1a_s2 <= PW'(d1x_s1) * PW'(qdy_s1);
			m1b_s2 <= PW'(d1y_s1) * PW'(qdx_s1);
			m2a_s2 <= PW'(qdx_s1) * PW'(d2y_s1);
			m2b_s2 <= PW'(qdy_s1) * PW'(d2x_s1);
			m3a_s2 <= PW'(e1x_s1) * PW'(pdy_s1);
			m3b_s2 <= PW'(e1y_s1) * PW'(pdx_s1);
			m4a_s2 <= PW'(pdx_s1) * PW'(e2y_s1);
			m4b_s2 <= PW'(pdy_s1) * PW'(e2x_s1);
			ovl_s2 <= ovl_s1;
		end
	end

	assign c1 = CW'(m1a_s2) - CW'(m1b_s2);
	assign c2 = CW'(m2a_s2) - CW'(m2b_s2);
	assign c3 = CW'(m3a_s2) - CW'(m3b_s2);
	assign c4 = CW'(m4a_s2) - CW'(m4b_s2);

	assign s1g = '{neg: c1[CW-1], pos: !c1[CW-1] && (|c1)};
	assign s2g = '{neg: c2[CW-1], pos: !c2[CW-1] && (|c2)};
	assign s3g = '{neg: c3[CW-1], pos: !c3[CW-1] && (|c3)};
	assign s4g = '{neg: c4[CW-1], pos: !c4[CW-1] && (|c4)};

	assign hit = ovl_s2 && product_nonneg(s1g, s2g) && product_nonneg(s3g, s4g);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			intersects_s3 <= hit;
		end
	end

	assign seg_out.valid      = v_s3;
	assign seg_out.intersects = intersects_s3;

endmodule

@@ sv/sit_checker.sv @@
// Port-level checks for the segment intersection test, bound to the top
// level. Uses sit_pkg for the pipeline depth.
`timescale 1ns / 1ps

module sit_checker
	import sit_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_intersects
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_intersects))
	else $error("Stalled result changed or vanished.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
	else $error("Input refused while the output register is empty.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(in_acc, 1) && !$past(in_acc, 2) && !$past(in_acc, PIPE_DEPTH) &&
		 $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, PIPE_DEPTH))
		|-> !out_valid)
	else $error("Result shown with no transaction left in the pipeline.");

	assert property (@(posedge clk)
		!arst_n |-> !out_valid)
	else $error("Result valid during reset.");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (seg_in.valid),
	.in_ready       (seg_in.ready),
	.out_valid      (seg_out.valid),
	.out_ready      (seg_out.ready),
	.out_intersects (seg_out.intersects)
);

@@ verif/segment_intersection_test_tb.sv @@
// Self-checking testbench for segment_intersection_test.
// Uses sit_pkg, the channel interfaces sit_in_if and sit_out_if and the block
// itself; results are predicted here and compared in order of arrival.
`timescale 1ns / 1ps

module segment_intersection_test_tb;
	import sit_pkg::*;

	localparam int COORD_WIDTH = 16;
	localparam int RANDOM_PER_PHASE = 470;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 4 * PIPE_DEPTH + 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SEND_IDLE[4] = '{0, 73, 0, 15};
	localparam int RECV_STALL[4] = '{0, 0, 73, 15};
	localparam int EXTREME_COORDS[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t a_start_x;
		coord_t a_start_y;
		coord_t a_end_x;
		coord_t a_end_y;
		coord_t b_start_x;
		coord_t b_start_y;
		coord_t b_end_x;
		coord_t b_end_y;
	} seg_pair_t;

	logic clk = 1'b0;
	logic arst_n;

	sit_in_if #(.COORD_WIDTH(COORD_WIDTH)) seg_in();
	sit_out_if seg_out();

	segment_intersection_test #(.COORD_WIDTH(COORD_WIDTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.seg_in  (seg_in),
		.seg_out (seg_out)
	);

	seg_pair_t pending_pairs[$];
	logic      expected_hits[$];
	seg_pair_t offered;
	logic      wanted_hit;
	int        send_idle_pct;
	int        recv_stall_pct;
	logic      hold_start;
	int        hold_left = 0;
	int        failures = 0;
	int        cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint lower_of(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic longint upper_of(longint a, longint b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic spans_overlap(longint a0, longint a1, longint b0, longint b1);
		return upper_of(lower_of(a0, a1), lower_of(b0, b1))
			<= lower_of(upper_of(a0, a1), upper_of(b0, b1));
	endfunction

	function automatic logic strictly_opposite(longint u, longint v);
		return (u > 0 && v < 0) || (u < 0 && v > 0);
	endfunction

	function automatic logic predict_intersects(seg_pair_t p);
		longint px0, py0, px1, py1, qx0, qy0, qx1, qy1;
		longint pdx, pdy, qdx, qdy;
		longint side_p0, side_p1, side_q0, side_q1;
		logic boxes_meet;
		px0 = longint'($signed(p.a_start_x));
		py0 = longint'($signed(p.a_start_y));
		px1 = longint'($signed(p.a_end_x));
		py1 = longint'($signed(p.a_end_y));
		qx0 = longint'($signed(p.b_start_x));
		qy0 = longint'($signed(p.b_start_y));
		qx1 = longint'($signed(p.b_end_x));
		qy1 = longint'($signed(p.b_end_y));
		boxes_meet = spans_overlap(px0, px1, qx0, qx1) && spans_overlap(py0, py1, qy0, qy1);
		pdx = px1 - px0;
		pdy = py1 - py0;
		qdx = qx1 - qx0;
		qdy = qy1 - qy0;
		side_p0 = (px0 - qx0) * qdy - (py0 - qy0) * qdx;
		side_p1 = qdx * (py1 - qy0) - qdy * (px1 - qx0);
		side_q0 = (qx0 - px0) * pdy - (qy0 - py0) * pdx;
		side_q1 = pdx * (qy1 - py0) - pdy * (qx1 - px0);
		return boxes_meet && !strictly_opposite(side_p0, side_p1)
			&& !strictly_opposite(side_q0, side_q1);
	endfunction

	function automatic seg_pair_t pair_from(int c[8]);
		seg_pair_t p;
		p.a_start_x = coord_t'(c[0]);
		p.a_start_y = coord_t'(c[1]);
		p.a_end_x   = coord_t'(c[2]);
		p.a_end_y   = coord_t'(c[3]);
		p.b_start_x = coord_t'(c[4]);
		p.b_start_y = coord_t'(c[5]);
		p.b_end_x   = coord_t'(c[6]);
		p.b_end_y   = coord_t'(c[7]);
		return p;
	endfunction

	function automatic seg_pair_t random_pair();
		int c[8];
		int kind, i, k, base_x, base_y, dx, dy;
		kind = $urandom_range(9);
		base_x = int'($urandom_range(64000)) - 32000;
		base_y = int'($urandom_range(64000)) - 32000;
		for (i = 0; i < 8; i++) begin
			c[i] = ((i % 2) == 0 ? base_x : base_y) + int'($urandom_range(16)) - 8;
		end
		case (kind)
			0, 1, 2, 3: begin
				for (i = 0; i < 8; i++) begin
					c[i] = int'($urandom);
				end
			end
			6, 7: begin
				base_x = int'($urandom_range(2000)) - 1000;
				base_y = int'($urandom_range(2000)) - 1000;
				dx = int'($urandom_range(120)) - 60;
				dy = int'($urandom_range(120)) - 60;
				for (i = 0; i < 4; i++) begin
					k = int'($urandom_range(16)) - 8;
					c[2 * i] = base_x + k * dx;
					c[2 * i + 1] = base_y + k * dy;
				end
			end
			8: begin
				for (i = 0; i < 8; i++) begin
					c[i] = EXTREME_COORDS[$urandom_range(6)];
				end
			end
			9: begin
				if ($urandom_range(1) == 0) begin
					c[2] = c[0];
					c[3] = c[1];
				end else begin
					c[4] = c[0];
					c[5] = c[1];
					c[6] = c[0];
					c[7] = c[1];
				end
			end
			default: begin
			end
		endcase
		return pair_from(c);
	endfunction

	task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
			int bx0, int by0, int bx1, int by1);
		int c[8];
		c = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
		pending_pairs.push_back(pair_from(c));
	endtask

	// Sender: a transaction stays on offer until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			seg_in.valid <= 1'b0;
		end else begin
			if (seg_in.valid && seg_in.ready) begin
				expected_hits.push_back(predict_intersects(offered));
			end
			if (!seg_in.valid || seg_in.ready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_pairs.pop_front();
					seg_in.a_start_x <= offered.a_start_x;
					seg_in.a_start_y <= offered.a_start_y;
					seg_in.a_end_x   <= offered.a_end_x;
					seg_in.a_end_y   <= offered.a_end_y;
					seg_in.b_start_x <= offered.b_start_x;
					seg_in.b_start_y <= offered.b_start_y;
					seg_in.b_end_x   <= offered.b_end_x;
					seg_in.b_end_y   <= offered.b_end_y;
					seg_in.valid     <= 1'b1;
				end else begin
					seg_in.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			seg_out.ready <= 1'b0;
		end else begin
			seg_out.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && seg_out.valid && seg_out.ready) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: result intersects=%0b arrived with none expected",
					$time, seg_out.intersects);
				failures++;
			end else begin
				wanted_hit = expected_hits.pop_front();
				if (seg_out.intersects !== wanted_hit) begin
					$display("%0t: intersects expected %0b, got %0b",
						$time, wanted_hit, seg_out.intersects);
					failures++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int phase, n;
		arst_n = 1'b0;
		seg_in.valid = 1'b0;
		seg_in.a_start_x = '0;
		seg_in.a_start_y = '0;
		seg_in.a_end_x = '0;
		seg_in.a_end_y = '0;
		seg_in.b_start_x = '0;
		seg_in.b_start_y = '0;
		seg_in.b_end_x = '0;
		seg_in.b_end_y = '0;
		seg_out.ready = 1'b0;
		hold_start = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		add_pair(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767);
		add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		add_pair(0, 0, 10, 10, 0, 10, 10, 0);
		add_pair(10, 10, 0, 0, 10, 0, 0, 10);
		add_pair(-5, -5, 5, 5, -5, 5, 5, -5);
		add_pair(0, 0, 10, 0, 5, 0, 5, 10);
		add_pair(0, 0, 5, 5, 5, 5, 9, 0);
		add_pair(0, 0, 10, 0, 5, 0, 15, 0);
		add_pair(0, 0, 5, 0, 5, 0, 9, 0);
		add_pair(0, 0, 4, 4, 5, 5, 9, 9);
		add_pair(-3, 7, 2, 7, -3, 7, 2, 7);
		add_pair(3, 3, 3, 3, 0, 0, 6, 6);
		add_pair(3, 4, 3, 4, 0, 0, 6, 6);
		add_pair(7, -7, 7, -7, 7, -7, 7, -7);
		add_pair(7, -7, 7, -7, 8, -7, 8, -7);
		add_pair(0, 0, 10, 0, 5, 5, 6, 20);
		add_pair(0, 0, 0, 10, 5, 5, 20, 6);
		add_pair(0, 0, 10, 10, 6, 0, 10, 3);
		add_pair(0, 0, 10, 10, 6, 5, 10, 0);

		for (phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			send_idle_pct = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			if (phase == 0) begin
				hold_start = 1'b1;
				@(negedge clk);
				hold_start = 1'b0;
			end
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				pending_pairs.push_back(random_pair());
			end
			while (pending_pairs.size() != 0 || seg_in.valid || expected_hits.size() != 0) begin
				@(negedge clk);
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/sit_pkg.sv
sv/sit_in_if.sv
sv/sit_out_if.sv
sv/segment_intersection_test.sv
sv/sit_checker.sv
verif/segment_intersection_test_tb.sv
